// ===== hdl/bsfd_pkg.sv =====
package bsfd_pkg;

    // Error codes carried by the result that closes a decoded frame
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_START = 3'd1,
        ERR_DELIM     = 3'd2,
        ERR_ESC_END   = 3'd3,
        ERR_BAD_END   = 3'd4,
        ERR_SHORT     = 3'd5
    } err_code_t;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_DECODE_MODE = 2'd0,
        REG_START_BYTE  = 2'd1,
        REG_END_BYTE    = 2'd2,
        REG_ESCAPE_BYTE = 2'd3
    } reg_idx_t;

    localparam logic [7:0] DEFAULT_DELIM = 8'h7E;
    localparam logic [7:0] DEFAULT_ESC   = 8'h7D;

    // Most results one input beat can cause: start, escape, data, end
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       frame_end;
        err_code_t  error_code;
    } result_t;

endpackage

// ===== hdl/byte_stuffing_framer_deframer_core.sv =====
// Byte-stuffing framer and deframer. With decode_mode at 0 the block takes
// data bytes and sends line bytes. A start byte goes out before the first byte
// of a frame. An escape goes out before any byte that equals the start, end or
// escape byte. An end byte goes out after the byte that is marked frame_last.
// With decode_mode at 1 the block takes line bytes, checks the framing, strips
// the escapes and sends the data bytes. The frame closes with a status beat
// (byte_valid 0) that carries error_code. After an error the rest of the frame
// is dropped until the closing beat. One input beat is taken each cycle. It
// causes zero to four output beats, and the output sends one beat per clock
// unless out_stall is high. The input is stalled while more than one beat
// of the last input is still waiting to go out, or while its final beat is
// held by out_stall. So only out_stall stalls the input when encoding a
// plain byte or decoding any byte; each start, escape or end added to an
// encoded byte stalls it too. run_last marks the last output beat that an
// input beat caused. Registers: decode_mode at 0x0, start_byte at 0x4,
// end_byte at 0x8 and escape_byte at 0xC. A write to decode_mode drops any
// open frame. Write the registers only while the block is idle.
module byte_stuffing_framer_deframer_core
    import bsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        frame_last,

    // Output beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        frame_end,
    output logic [2:0]  error_code,
    output logic        run_last
);

    // Configuration registers
    logic       decode_mode_reg;
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] escape_byte_reg;

    // Frame state
    logic       inside_reg,  inside_next;
    logic       esc_pend_reg, esc_pend_next;
    err_code_t  held_err_reg, held_err_next;

    // Result buffer: the results of one input beat, sent out in order
    result_t           res_reg  [MAX_RESULTS];
    result_t           res_next [MAX_RESULTS];
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  res_cnt;
    logic [SLOT_W-1:0] ptr_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;
    logic     in_fire;
    logic     out_fire;
    logic     is_special;
    result_t  head;

    // ------------------------------------------------------------------
    // Configuration port: always ready, register picked by paddr[3:2]
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_DECODE_MODE: prdata = {31'd0, decode_mode_reg};
            REG_START_BYTE:  prdata = {24'd0, start_byte_reg};
            REG_END_BYTE:    prdata = {24'd0, end_byte_reg};
            REG_ESCAPE_BYTE: prdata = {24'd0, escape_byte_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: take a new beat once at most the final result of the
    // previous one is still waiting and that result leaves this cycle
    // ------------------------------------------------------------------
    assign out_valid = (rem_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign in_stall  = (rem_reg > CNT_W'(1)) || ((rem_reg == CNT_W'(1)) && out_stall);
    assign in_fire   = in_valid && !in_stall;

    assign head       = res_reg[ptr_reg];
    assign out_byte   = head.data;
    assign byte_valid = head.byte_valid;
    assign frame_end  = head.frame_end;
    assign error_code = head.error_code;
    assign run_last   = (rem_reg == CNT_W'(1));

    assign is_special = (in_byte == start_byte_reg) || (in_byte == end_byte_reg)
                     || (in_byte == escape_byte_reg);

    // ------------------------------------------------------------------
    // Results of one input beat and the next frame state
    // ------------------------------------------------------------------
    always_comb
    begin
        res_cnt       = '0;
        inside_next   = inside_reg;
        esc_pend_next = esc_pend_reg;
        held_err_next = held_err_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = '{data: 8'd0, byte_valid: 1'b0, frame_end: 1'b0,
                            error_code: ERR_NONE};
        end

        if (!decode_mode_reg)
        begin
            // Encode: [start] [escape] data [end]
            if (!inside_reg)
            begin
                res_next[res_cnt[SLOT_W-1:0]].data       = start_byte_reg;
                res_next[res_cnt[SLOT_W-1:0]].byte_valid = 1'b1;
                res_cnt = res_cnt + CNT_W'(1);
            end
            if (is_special)
            begin
                res_next[res_cnt[SLOT_W-1:0]].data       = escape_byte_reg;
                res_next[res_cnt[SLOT_W-1:0]].byte_valid = 1'b1;
                res_cnt = res_cnt + CNT_W'(1);
            end
            res_next[res_cnt[SLOT_W-1:0]].data       = in_byte;
            res_next[res_cnt[SLOT_W-1:0]].byte_valid = 1'b1;
            res_cnt = res_cnt + CNT_W'(1);
            if (frame_last)
            begin
                res_next[res_cnt[SLOT_W-1:0]].data       = end_byte_reg;
                res_next[res_cnt[SLOT_W-1:0]].byte_valid = 1'b1;
                res_next[res_cnt[SLOT_W-1:0]].frame_end  = 1'b1;
                res_cnt       = res_cnt + CNT_W'(1);
                inside_next   = 1'b0;
                esc_pend_next = 1'b0;
                held_err_next = ERR_NONE;
            end
            else
            begin
                inside_next = 1'b1;
            end
        end
        else if (!inside_reg)
        begin
            // Decode, first byte: must be the start byte
            inside_next   = 1'b1;
            esc_pend_next = 1'b0;
            held_err_next = (in_byte != start_byte_reg) ? ERR_BAD_START : ERR_NONE;
            if (frame_last)
            begin
                res_next[0].frame_end  = 1'b1;
                res_next[0].error_code = (in_byte != start_byte_reg) ? ERR_BAD_START
                                                                     : ERR_SHORT;
                res_cnt       = CNT_W'(1);
                inside_next   = 1'b0;
                held_err_next = ERR_NONE;
            end
        end
        else if (frame_last)
        begin
            // Decode, closing byte: report the first error found
            res_next[0].frame_end = 1'b1;
            if (held_err_reg != ERR_NONE)
                res_next[0].error_code = held_err_reg;
            else if (in_byte != end_byte_reg)
                res_next[0].error_code = ERR_BAD_END;
            else if (esc_pend_reg)
                res_next[0].error_code = ERR_ESC_END;
            else
                res_next[0].error_code = ERR_NONE;
            res_cnt       = CNT_W'(1);
            inside_next   = 1'b0;
            esc_pend_next = 1'b0;
            held_err_next = ERR_NONE;
        end
        else if (held_err_reg != ERR_NONE)
        begin
            // Drop the byte until the frame closes
            res_cnt = '0;
        end
        else if (esc_pend_reg)
        begin
            esc_pend_next          = 1'b0;
            res_next[0].data       = in_byte;
            res_next[0].byte_valid = 1'b1;
            res_cnt                = CNT_W'(1);
        end
        else if (in_byte == escape_byte_reg)
        begin
            esc_pend_next = 1'b1;
        end
        else if ((in_byte == start_byte_reg) || (in_byte == end_byte_reg))
        begin
            held_err_next = ERR_DELIM;
        end
        else
        begin
            res_next[0].data       = in_byte;
            res_next[0].byte_valid = 1'b1;
            res_cnt                = CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            start_byte_reg  <= DEFAULT_DELIM;
            end_byte_reg    <= DEFAULT_DELIM;
            escape_byte_reg <= DEFAULT_ESC;
            inside_reg      <= 1'b0;
            esc_pend_reg    <= 1'b0;
            held_err_reg    <= ERR_NONE;
            rem_reg         <= '0;
            ptr_reg         <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_DECODE_MODE:
                    begin
                        // Drop any open frame on a mode change
                        decode_mode_reg <= pwdata[0];
                        inside_reg      <= 1'b0;
                        esc_pend_reg    <= 1'b0;
                        held_err_reg    <= ERR_NONE;
                    end
                    REG_START_BYTE:  start_byte_reg  <= pwdata[7:0];
                    REG_END_BYTE:    end_byte_reg    <= pwdata[7:0];
                    REG_ESCAPE_BYTE: escape_byte_reg <= pwdata[7:0];
                    default:         decode_mode_reg <= decode_mode_reg;
                endcase
            end
            else if (in_fire)
            begin
                inside_reg   <= inside_next;
                esc_pend_reg <= esc_pend_next;
                held_err_reg <= held_err_next;
            end

            if (in_fire)
            begin
                rem_reg <= res_cnt;
                ptr_reg <= '0;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
                ptr_reg <= ptr_reg + SLOT_W'(1);
            end
        end
    end

    // Result payload: load on an accepted input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

// ===== hdl/bsfd_checker.sv =====
module bsfd_checker
    import bsfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       frame_end,
    input logic [2:0] error_code,
    input logic       run_last
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(frame_end) && $stable(error_code)
            && $stable(run_last))
        else $error("stalled output beat changed");

    // The closing beat is always the last beat of its input
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame end not on last beat of its input");

    // An error code only rides on a status beat that closes the frame
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> frame_end && !byte_valid)
        else $error("error code outside a closing status beat");

    // A status beat carries a zero byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> (out_byte == 8'd0) && frame_end)
        else $error("status beat with byte data");

    // Stall the input while more beats of the current input remain
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input taken while results still pending");

endmodule

bind byte_stuffing_framer_deframer_core bsfd_checker u_bsfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .frame_end  (frame_end),
    .error_code (error_code),
    .run_last   (run_last)
);

// ===== sim/bsfd_stuffing_checker.sv =====
module bsfd_stuffing_checker
    import bsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        frame_last,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        frame_end,
    input  logic [2:0]  error_code,
    input  logic        run_last,

    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [7:0] data;
        logic       byte_valid;
        logic       frame_end;
        err_code_t  error_code;
        logic       run_last;
    } line_beat_t;

    line_beat_t out_beats_q[$];

    // Shadow copy of the registers and the framing state
    logic       decode_mode;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic       inside_frame;
    logic       escape_pending;
    err_code_t  held_error;
    int         errors;

    function automatic logic is_special(logic [7:0] b);
        return (b == start_byte) || (b == end_byte) || (b == escape_byte);
    endfunction

    task automatic clear_frame();
        inside_frame   = 1'b0;
        escape_pending = 1'b0;
        held_error     = ERR_NONE;
    endtask

    task automatic report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic push_beat(logic [7:0] d, logic bv, logic fe, err_code_t ec);
        line_beat_t r;
        r.data       = d;
        r.byte_valid = bv;
        r.frame_end  = fe;
        r.error_code = ec;
        r.run_last   = 1'b0;
        out_beats_q.push_back(r);
    endtask

    task automatic stuff_byte(logic [7:0] b, logic last);
        if (!inside_frame) begin
            push_beat(start_byte, 1'b1, 1'b0, ERR_NONE);
            inside_frame = 1'b1;
        end
        if (is_special(b))
            push_beat(escape_byte, 1'b1, 1'b0, ERR_NONE);
        push_beat(b, 1'b1, 1'b0, ERR_NONE);
        if (last) begin
            push_beat(end_byte, 1'b1, 1'b1, ERR_NONE);
            clear_frame();
        end
    endtask

    task automatic destuff_byte(logic [7:0] b, logic last);
        err_code_t err;
        if (!inside_frame) begin
            inside_frame   = 1'b1;
            escape_pending = 1'b0;
            held_error     = (b != start_byte) ? ERR_BAD_START : ERR_NONE;
            if (last) begin
                err = (held_error != ERR_NONE) ? held_error : ERR_SHORT;
                push_beat(8'h00, 1'b0, 1'b1, err);
                clear_frame();
            end
            return;
        end
        if (last) begin
            if (held_error != ERR_NONE)
                err = held_error;
            else if (b != end_byte)
                err = ERR_BAD_END;
            else if (escape_pending)
                err = ERR_ESC_END;
            else
                err = ERR_NONE;
            push_beat(8'h00, 1'b0, 1'b1, err);
            clear_frame();
            return;
        end
        if (held_error != ERR_NONE)
            return;
        if (escape_pending) begin
            escape_pending = 1'b0;
            push_beat(b, 1'b1, 1'b0, ERR_NONE);
        end else if (b == escape_byte) begin
            escape_pending = 1'b1;
        end else if (b == start_byte || b == end_byte) begin
            held_error = ERR_DELIM;
        end else begin
            push_beat(b, 1'b1, 1'b0, ERR_NONE);
        end
    endtask

    task automatic predict_line_beats(logic [7:0] b, logic last);
        int n0;
        n0 = out_beats_q.size();
        if (decode_mode)
            destuff_byte(b, last);
        else
            stuff_byte(b, last);
        if (out_beats_q.size() > n0)
            out_beats_q[out_beats_q.size() - 1].run_last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        line_beat_t got;
        line_beat_t want;
        if (!rst_n) begin
            decode_mode = 1'b0;
            start_byte  = DEFAULT_DELIM;
            end_byte    = DEFAULT_DELIM;
            escape_byte = DEFAULT_ESC;
            clear_frame();
            out_beats_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_DECODE_MODE: begin
                        decode_mode = pwdata[0];
                        clear_frame();
                    end
                    REG_START_BYTE:  start_byte  = pwdata[7:0];
                    REG_END_BYTE:    end_byte    = pwdata[7:0];
                    REG_ESCAPE_BYTE: escape_byte = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_line_beats(in_byte, frame_last);
            if (out_valid && !out_stall) begin
                got.data       = out_byte;
                got.byte_valid = byte_valid;
                got.frame_end  = frame_end;
                got.error_code = err_code_t'(error_code);
                got.run_last   = run_last;
                if (out_beats_q.size() == 0) begin
                    report($sformatf("unexpected beat byte=%02h bv=%b fe=%b err=%0d rl=%b",
                                     got.data, got.byte_valid, got.frame_end,
                                     got.error_code, got.run_last));
                end else begin
                    want = out_beats_q.pop_front();
                    if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                        got.frame_end !== want.frame_end ||
                        got.error_code !== want.error_code ||
                        got.run_last !== want.run_last)
                        report($sformatf({"got byte=%02h bv=%b fe=%b err=%0d rl=%b, ",
                                          "want byte=%02h bv=%b fe=%b err=%0d rl=%b"},
                                         got.data, got.byte_valid, got.frame_end,
                                         got.error_code, got.run_last,
                                         want.data, want.byte_valid, want.frame_end,
                                         want.error_code, want.run_last));
                end
            end
        end
        fail_count <= errors;
        pending    <= out_beats_q.size();
    end

endmodule

// ===== sim/tb_byte_stuffing_framer_deframer_core.sv =====
module tb_byte_stuffing_framer_deframer_core;
    import bsfd_pkg::*;

    localparam int  ITEM_TARGET    = 320;
    localparam int  PHASE_BEATS    = 36;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 16;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam logic MODE_ENCODE   = 1'b0;
    localparam logic MODE_DECODE   = 1'b1;

    // Ways to spoil a generated line frame
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_START,
        FLAW_DELIM,
        FLAW_ESC_END,
        FLAW_BAD_END,
        FLAW_NOISE
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        frame_last = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [2:0]  error_code;
    logic        run_last;

    int          fail_count;
    int          pending;

    // Stimulus side view of the registers, used only to shape the stimulus
    logic        cfg_mode;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    logic [7:0]  cfg_esc;

    int          beats_sent = 0;
    logic        hold_req = 1'b0;   // ask the receiver for one long hold-off
    logic        quiet = 1'b0;      // no idling on either side while set
    int          idle_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    byte_stuffing_framer_deframer_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .frame_end  (frame_end),
        .error_code (error_code),
        .run_last   (run_last)
    );

    bsfd_stuffing_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .frame_end  (frame_end),
        .error_code (error_code),
        .run_last   (run_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Pick an idle gap: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Lean toward the special bytes so stuffing and errors come up often
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return cfg_start;
            2:       return cfg_end;
            3:       return cfg_esc;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Two-phase register write; always called and left at a rising edge
    task automatic apb_write(reg_idx_t idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every expected beat, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic mode, logic [7:0] s, logic [7:0] e, logic [7:0] x);
        settle();
        apb_write(REG_START_BYTE, s);
        apb_write(REG_END_BYTE, e);
        apb_write(REG_ESCAPE_BYTE, x);
        apb_write(REG_DECODE_MODE, {7'h0, mode});
        cfg_mode  = mode;
        cfg_start = s;
        cfg_end   = e;
        cfg_esc   = x;
    endtask

    // Offer one input beat after a random gap and hold it until accepted.
    // Valid stays high across back-to-back beats so it is never toggled
    // twice in one step.
    task automatic send_beat(logic [7:0] b, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        frame_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_data_frame(int len);
        for (int i = 0; i < len; i++)
            send_beat(pick_byte(), i == len - 1);
    endtask

    // Build a stuffed line frame with the current delimiters, spoil it as
    // asked, and send it with frame_last on the final byte
    task automatic send_line_frame(int len, flaw_t flaw);
        logic [7:0] line_q[$];
        logic [7:0] d;
        int         pos;
        int         n;
        if (flaw == FLAW_NOISE) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        line_q.push_back(flaw == FLAW_BAD_START ? 8'($urandom_range(0, 255)) : cfg_start);
        for (int i = 0; i < len; i++) begin
            d = pick_byte();
            if (d == cfg_start || d == cfg_end || d == cfg_esc)
                line_q.push_back(cfg_esc);
            line_q.push_back(d);
        end
        if (flaw == FLAW_DELIM) begin
            pos = $urandom_range(1, line_q.size());
            line_q.insert(pos, $urandom_range(0, 1) ? cfg_start : cfg_end);
        end
        if (flaw == FLAW_ESC_END)
            line_q.push_back(cfg_esc);
        line_q.push_back(flaw == FLAW_BAD_END ? 8'($urandom_range(0, 255)) : cfg_end);
        foreach (line_q[i])
            send_beat(line_q[i], i == line_q.size() - 1);
    endtask

    // Receiver: hold out_stall for runs of random length; grant one long
    // hold-off on request so the block backs up and stalls its input
    initial
    begin
        int r;
        int len;
        @(posedge clk);
        forever
        begin
            if (hold_req) begin
                out_stall <= 1'b1;
                len = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (quiet || r < 60) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else if (r < 96) begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 4);
                end else begin
                    out_stall <= 1'b1;
                    len = $urandom_range(20, 60);
                end
            end
            repeat (len) @(posedge clk);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic  mode;
        logic [7:0] s;
        logic [7:0] e;
        logic [7:0] x;
        int    phase_start;
        flaw_t flaw;

        cfg_mode  = MODE_ENCODE;
        cfg_start = DEFAULT_DELIM;
        cfg_end   = DEFAULT_DELIM;
        cfg_esc   = DEFAULT_ESC;

        // Hold reset low, then release it once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode at reset values: byte extremes, both delimiters, escape,
        // a one-byte frame, and a frame left open for the mode write
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(DEFAULT_ESC, 1'b1);
        send_beat(8'h41, 1'b1);
        send_beat(8'h5A, 1'b0);

        // Switch to decode; the open frame must be dropped
        set_config(MODE_DECODE, DEFAULT_DELIM, DEFAULT_DELIM, DEFAULT_ESC);

        // Good frame with an escaped byte
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(DEFAULT_ESC, 1'b0);
        send_beat(8'h5E, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b1);
        // One-byte frames: start byte alone is too short, anything else bad start
        send_beat(DEFAULT_DELIM, 1'b1);
        send_beat(8'h00, 1'b1);
        // Bad start, the rest swallowed
        send_beat(8'h11, 1'b0);
        send_beat(8'h22, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b1);
        // Unescaped delimiter inside the frame
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(8'h33, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b1);
        // Escape right before the end byte
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(DEFAULT_ESC, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b1);
        // Last byte is not the end byte
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(8'h44, 1'b0);
        send_beat(8'h55, 1'b1);
        // Start and end only
        send_beat(DEFAULT_DELIM, 1'b0);
        send_beat(DEFAULT_DELIM, 1'b1);

        // Random phases: fixed extreme settings first, then random ones,
        // until enough beats have gone in
        for (int phase = 0; phase < 8 || beats_sent < ITEM_TARGET; phase++) begin
            case (phase)
                0: begin mode = MODE_ENCODE; s = DEFAULT_DELIM; e = DEFAULT_DELIM; x = DEFAULT_ESC; end
                1: begin mode = MODE_DECODE; s = DEFAULT_DELIM; e = DEFAULT_DELIM; x = DEFAULT_ESC; end
                2: begin mode = MODE_ENCODE; s = 8'h00; e = 8'hFF; x = 8'h80; end
                3: begin mode = MODE_DECODE; s = 8'h00; e = 8'hFF; x = 8'h80; end
                4: begin mode = MODE_DECODE; s = 8'hFF; e = 8'hFF; x = 8'h00; end
                5: begin mode = MODE_ENCODE; s = 8'hFF; e = 8'hFF; x = 8'h00; end
                default: begin
                    mode = phase[0] ? MODE_DECODE : MODE_ENCODE;
                    s = 8'($urandom_range(0, 255));
                    e = ($urandom_range(0, 1) != 0) ? s : 8'($urandom_range(0, 255));
                    x = 8'($urandom_range(0, 255));
                end
            endcase
            set_config(mode, s, e, x);

            // Phase 2 backs the block up; phase 3 runs with no idling
            if (phase == 2)
                hold_req = 1'b1;
            quiet = (phase == 3);

            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (cfg_mode == MODE_DECODE) begin
                    flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE
                                                      : flaw_t'($urandom_range(1, 5));
                    send_line_frame($urandom_range(0, 6), flaw);
                end else begin
                    send_data_frame($urandom_range(1, 6));
                end
            end
        end
        quiet = 1'b0;

        // Drain everything still expected, then give the verdict
        settle();
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bsfd_pkg.sv
hdl/byte_stuffing_framer_deframer_core.sv
hdl/bsfd_checker.sv
sim/bsfd_stuffing_checker.sv
sim/tb_byte_stuffing_framer_deframer_core.sv
